// ===== rtl/spectrum_energy_level_detector_defines.svh =====
// Assertion shorthands shared by the RTL files.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef SPECTRUM_ENERGY_LEVEL_DETECTOR_DEFINES_SVH
`define SPECTRUM_ENERGY_LEVEL_DETECTOR_DEFINES_SVH

// Check a condition at every edge outside reset.
`define SELD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define SELD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define SELD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/seld_pkg.sv =====
package seld_pkg;

  // Default geometry of the spectrum window
  localparam int NUM_BINS_DEF      = 512;
  localparam int WINDOW_HEIGHT_DEF = 350;

  // Field widths
  localparam int MAG_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int BAND_W  = 10;
  localparam int LVL_W   = 17;
  localparam int INTV_W  = 16;
  localparam int MS_W    = 32;
  localparam int CUT_W   = 7;
  localparam int SUM_W   = 26;
  localparam int BINS_W  = 10;
  localparam int CLASS_W = 2;

  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [BINS_W-1:0] BINS_MAX  = {BINS_W{1'b1}};
  localparam logic [LVL_W-1:0]  ONE_Q16   = 17'h10000;
  localparam int                ROUND_Q16 = 32768;
  localparam logic [CUT_W-1:0]  CUT_WRAP  = 7'd100;

  // Ratio divider: one quotient bit per step
  localparam int DIV_STEPS = LVL_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN        = 3'd0,
    CFG_BAND_START  = 3'd1,
    CFG_USE_MIXDOWN = 3'd2,
    CFG_SMOOTHING   = 3'd3,
    CFG_THRESHOLD_A = 3'd4,
    CFG_THRESHOLD_B = 3'd5,
    CFG_THRESHOLD_C = 3'd6,
    CFG_CUT_INTV    = 3'd7
  } cfg_index_t;

  localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd256;
  localparam logic [BAND_W-1:0] BAND_RST      = 10'd128;
  localparam logic [LVL_W-1:0]  SMOOTH_RST    = 17'd6554;
  localparam logic [LVL_W-1:0]  THR_A_RST     = 17'd6554;
  localparam logic [LVL_W-1:0]  THR_B_RST     = 17'd19661;
  localparam logic [LVL_W-1:0]  THR_C_RST     = 17'd32768;
  localparam logic [INTV_W-1:0] CUT_INTV_RST  = 16'd2000;

  // Input command codes
  localparam logic CMD_BIN  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_CALM = 2'd0,
    CLASS_LOW  = 2'd1,
    CLASS_HIGH = 2'd2
  } level_class_t;

  typedef struct packed {
    logic              command;
    logic [MAG_W-1:0]  bin_normal;
    logic [MAG_W-1:0]  bin_mixdown;
    logic              frame_end;
  } seld_in_t;

  typedef struct packed {
    logic [LVL_W-1:0]   energy_level;
    logic [CLASS_W-1:0] level_class;
    logic               cut_change;
    logic [CUT_W-1:0]   cut_count;
  } seld_out_t;

  // Controller to datapath
  typedef struct packed {
    logic acc;
    logic tick;
    logic denom;
    logic prep;
    logic div_step;
    logic mul_new;
    logic mul_old;
    logic blend;
    logic classify;
  } seld_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
  } seld_status_t;

endpackage

// ===== rtl/seld_stream_if.sv =====
interface seld_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/seld_ctrl.sv =====
`include "spectrum_energy_level_detector_defines.svh"

module seld_ctrl
  import seld_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_command,
  input  logic         in_frame_end,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output seld_cmd_t    cmd,
  input  seld_status_t status
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DENOM   = 8'b0000_0010,
    S_PREP    = 8'b0000_0100,
    S_DIV     = 8'b0000_1000,
    S_MUL_NEW = 8'b0001_0000,
    S_MUL_OLD = 8'b0010_0000,
    S_BLEND   = 8'b0100_0000,
    S_CLASS   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_TICK) begin
            cmd.tick = 1'b1;
          end else begin
            cmd.acc = 1'b1;
            if (in_frame_end) begin
              state_next = S_DENOM;
            end
          end
        end
      end
      S_DENOM: begin
        cmd.denom  = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_MUL_NEW;
        end
      end
      S_MUL_NEW: begin
        cmd.mul_new = 1'b1;
        state_next  = S_MUL_OLD;
      end
      S_MUL_OLD: begin
        cmd.mul_old = 1'b1;
        state_next  = S_BLEND;
      end
      S_BLEND: begin
        cmd.blend  = 1'b1;
        state_next = S_CLASS;
      end
      S_CLASS: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.classify = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.classify) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SELD_ASSERT_NEXT(ctl_frame_start, in_valid && in_ready && in_command == CMD_BIN && in_frame_end, state == S_DENOM, "frame end did not start the ratio pass")
  `SELD_ASSERT_IMPL(ctl_out_source, $rose(out_valid), $past(state) == S_CLASS, "result word raised outside classification")
  `SELD_ASSERT_IMPL(ctl_no_overwrite, cmd.classify, !out_valid || out_ready, "classification overwrote a pending word")

endmodule

// ===== rtl/seld_datapath.sv =====
`include "spectrum_energy_level_detector_defines.svh"

module seld_datapath
  import seld_pkg::*;
#(
  parameter int NUM_BINS      = NUM_BINS_DEF,
  parameter int WINDOW_HEIGHT = WINDOW_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  seld_cmd_t             cmd,
  output seld_status_t          status,
  input  seld_in_t              in_word,
  output seld_out_t             out_word
);

  localparam int POS_W = $clog2(NUM_BINS + 1);
  localparam int CMP_W = ((POS_W > BAND_W) ? POS_W : BAND_W) + 1;
  localparam int WH_W  = $clog2(WINDOW_HEIGHT + 1);
  localparam int HGT_W = WH_W + FRAC_W;
  localparam int SCL_W = MAG_W + GAIN_W - FRAC_W;
  localparam int DEN_W = BINS_W + WH_W;
  localparam int REM_W = DEN_W + 1;
  localparam int NUM_W = SUM_W + FRAC_W;
  localparam int CHK_W = ((NUM_W > DEN_W + DIV_STEPS) ? NUM_W : DEN_W + DIV_STEPS) + 1;
  localparam int PRD_W = 2 * LVL_W;

  localparam logic [HGT_W-1:0] HEIGHT_MAX = HGT_W'(WINDOW_HEIGHT * 256);
  localparam logic [POS_W-1:0] POS_MAX    = POS_W'(NUM_BINS);
  localparam logic [CMP_W-1:0] NB_X       = CMP_W'(NUM_BINS);

  // configuration
  logic [GAIN_W-1:0] gain;
  logic [BAND_W-1:0] band_start;
  logic              use_mixdown;
  logic [LVL_W-1:0]  smoothing;
  logic [LVL_W-1:0]  threshold_a;
  logic [LVL_W-1:0]  threshold_b;
  logic [LVL_W-1:0]  threshold_c;
  logic [INTV_W-1:0] cut_interval_ms;

  // frame and level state
  logic [POS_W-1:0]  bin_position;
  logic [SUM_W-1:0]  band_sum;
  logic [BINS_W-1:0] band_bins;
  logic [LVL_W-1:0]  smoothed_level;
  level_class_t      level_state;
  logic [MS_W-1:0]   now_ms;
  logic [MS_W-1:0]   last_cut_ms;
  logic [CUT_W-1:0]  cut_counter;

  // ratio pass
  logic [DEN_W-1:0]     den;
  logic [REM_W-1:0]     rem;
  logic [DIV_STEPS-1:0] num_lo;
  logic [LVL_W-1:0]     quo;
  logic                 empty;
  logic                 sat;
  logic [DCNT_W-1:0]    div_cnt;
  logic [PRD_W-1:0]     prod_a;
  logic [PRD_W-1:0]     prod_b;

  // bin scaling and band membership
  logic [MAG_W-1:0]          mag;
  logic [MAG_W+GAIN_W-1:0]   scaled_full;
  logic [SCL_W-1:0]          scaled;
  logic [HGT_W-1:0]          height;
  logic [SUM_W:0]            sum_ext;
  logic [SUM_W-1:0]          band_sum_next;
  logic [CMP_W-1:0]          pos_x;
  logic [CMP_W-1:0]          bs_x;
  logic                      in_band;

  assign mag         = use_mixdown ? in_word.bin_mixdown : in_word.bin_normal;
  assign scaled_full = (MAG_W+GAIN_W)'(mag) * (MAG_W+GAIN_W)'(gain);
  assign scaled      = scaled_full[MAG_W+GAIN_W-1:FRAC_W];
  assign height      = (scaled > SCL_W'(HEIGHT_MAX)) ? HEIGHT_MAX : scaled[HGT_W-1:0];
  assign sum_ext     = (SUM_W+1)'(band_sum) + (SUM_W+1)'(height);
  assign band_sum_next = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

  assign pos_x   = CMP_W'(bin_position);
  assign bs_x    = CMP_W'(band_start);
  assign in_band = (pos_x >= bs_x) && (bs_x <= NB_X) && ((pos_x + bs_x) < NB_X);

  // divider
  logic [NUM_W-1:0] num_full;
  logic             sat_c;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] den_x;
  logic             q_bit;

  assign num_full = {band_sum, {FRAC_W{1'b0}}};
  assign sat_c    = CHK_W'(num_full) >= (CHK_W'(den) << DIV_STEPS);
  assign rem_sh   = {rem[REM_W-2:0], num_lo[DIV_STEPS-1]};
  assign den_x    = REM_W'(den);
  assign q_bit    = (rem_sh >= den_x);

  assign status.div_last = (div_cnt == DCNT_W'(DIV_STEPS - 1));

  // low-pass on a shared multiplier
  logic [LVL_W-1:0]   ratio;
  logic [LVL_W-1:0]   weight;
  logic [LVL_W-1:0]   weight_old;
  logic [LVL_W-1:0]   mul_x;
  logic [LVL_W-1:0]   mul_y;
  logic [PRD_W-1:0]   mul_p;
  logic [PRD_W:0]     blend_sum;

  always_comb begin
    if (empty) begin
      ratio = '0;
    end else if (sat || (quo > ONE_Q16)) begin
      ratio = ONE_Q16;
    end else begin
      ratio = quo;
    end
  end

  assign weight     = (smoothing > ONE_Q16) ? ONE_Q16 : smoothing;
  assign weight_old = ONE_Q16 - weight;
  assign mul_x      = cmd.mul_new ? ratio  : smoothed_level;
  assign mul_y      = cmd.mul_new ? weight : weight_old;
  assign mul_p      = PRD_W'(mul_x) * PRD_W'(mul_y);
  assign blend_sum  = (PRD_W+1)'(prod_a) + (PRD_W+1)'(prod_b) + (PRD_W+1)'(ROUND_Q16);

  // threshold sort, three compare-exchange steps
  logic [LVL_W-1:0] s1_lo, s1_hi, s2_lo, th_high, th_calm, th_low;

  always_comb begin
    s1_lo   = (threshold_a > threshold_b) ? threshold_b : threshold_a;
    s1_hi   = (threshold_a > threshold_b) ? threshold_a : threshold_b;
    s2_lo   = (s1_hi > threshold_c) ? threshold_c : s1_hi;
    th_high = (s1_hi > threshold_c) ? s1_hi : threshold_c;
    th_calm = (s1_lo > s2_lo) ? s2_lo : s1_lo;
    th_low  = (s1_lo > s2_lo) ? s1_lo : s2_lo;
  end

  // hysteresis and cut event
  level_class_t      class_next;
  logic              go_high;
  logic              cut_fire;
  logic [MS_W-1:0]   elapsed;
  logic [CUT_W-1:0]  cut_counter_next;

  always_comb begin
    class_next = level_state;
    go_high    = 1'b0;
    case (level_state)
      CLASS_HIGH: begin
        if (smoothed_level < th_calm) begin
          class_next = CLASS_CALM;
        end else if (smoothed_level < th_low) begin
          class_next = CLASS_LOW;
        end
      end
      CLASS_LOW: begin
        if (th_high < smoothed_level) begin
          class_next = CLASS_HIGH;
          go_high    = 1'b1;
        end else if (smoothed_level < th_calm) begin
          class_next = CLASS_CALM;
        end
      end
      default: begin
        if (th_high < smoothed_level) begin
          class_next = CLASS_HIGH;
          go_high    = 1'b1;
        end
      end
    endcase
  end

  assign elapsed  = now_ms - last_cut_ms;
  assign cut_fire = go_high && (MS_W'(cut_interval_ms) < elapsed);

  always_comb begin
    cut_counter_next = cut_counter;
    if (cut_fire) begin
      cut_counter_next = (cut_counter >= CUT_WRAP) ? '0 : cut_counter + 1'b1;
    end
  end

  // control-bearing state
  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= GAIN_RST;
      band_start      <= BAND_RST;
      use_mixdown     <= 1'b0;
      smoothing       <= SMOOTH_RST;
      threshold_a     <= THR_A_RST;
      threshold_b     <= THR_B_RST;
      threshold_c     <= THR_C_RST;
      cut_interval_ms <= CUT_INTV_RST;
      bin_position    <= '0;
      band_sum        <= '0;
      band_bins       <= '0;
      smoothed_level  <= '0;
      level_state     <= CLASS_CALM;
      now_ms          <= '0;
      last_cut_ms     <= '0;
      cut_counter     <= '0;
      div_cnt         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_GAIN:        gain            <= cfg_data[GAIN_W-1:0];
          CFG_BAND_START:  band_start      <= cfg_data[BAND_W-1:0];
          CFG_USE_MIXDOWN: use_mixdown     <= cfg_data[0];
          CFG_SMOOTHING:   smoothing       <= cfg_data[LVL_W-1:0];
          CFG_THRESHOLD_A: threshold_a     <= cfg_data[LVL_W-1:0];
          CFG_THRESHOLD_B: threshold_b     <= cfg_data[LVL_W-1:0];
          CFG_THRESHOLD_C: threshold_c     <= cfg_data[LVL_W-1:0];
          CFG_CUT_INTV:    cut_interval_ms <= cfg_data[INTV_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.tick) begin
        now_ms <= now_ms + 1'b1;
      end
      if (cmd.acc) begin
        if (in_band) begin
          band_sum <= band_sum_next;
          if (band_bins != BINS_MAX) begin
            band_bins <= band_bins + 1'b1;
          end
        end
        if (bin_position < POS_MAX) begin
          bin_position <= bin_position + 1'b1;
        end
      end
      if (cmd.prep) begin
        bin_position <= '0;
        band_sum     <= '0;
        band_bins    <= '0;
        div_cnt      <= '0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.blend) begin
        smoothed_level <= blend_sum[LVL_W+15:16];
      end
      if (cmd.classify) begin
        level_state <= class_next;
        cut_counter <= cut_counter_next;
        if (cut_fire) begin
          last_cut_ms <= now_ms;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.denom) begin
      den <= DEN_W'(band_bins) * DEN_W'(WINDOW_HEIGHT);
    end
    if (cmd.prep) begin
      empty  <= (band_bins == '0);
      sat    <= sat_c;
      rem    <= REM_W'(num_full[NUM_W-1:DIV_STEPS]);
      num_lo <= num_full[DIV_STEPS-1:0];
    end
    if (cmd.div_step) begin
      rem    <= q_bit ? (rem_sh - den_x) : rem_sh;
      quo    <= {quo[LVL_W-2:0], q_bit};
      num_lo <= {num_lo[DIV_STEPS-2:0], 1'b0};
    end
    if (cmd.mul_new) begin
      prod_a <= mul_p;
    end
    if (cmd.mul_old) begin
      prod_b <= mul_p;
    end
    if (cmd.classify) begin
      out_word.energy_level <= smoothed_level;
      out_word.level_class  <= class_next;
      out_word.cut_change   <= cut_fire;
      out_word.cut_count    <= cut_counter_next;
    end
  end

  `SELD_ASSERT(dp_cut_wrap, cut_counter <= CUT_WRAP, "cut counter beyond its wrap point")
  `SELD_ASSERT(dp_level_range, smoothed_level <= ONE_Q16, "smoothed level above one")
  `SELD_ASSERT_IMPL(dp_div_rem, cmd.div_step && !empty && !sat, rem < den_x, "divider remainder not below divisor")
  `SELD_ASSERT_IMPL(dp_div_count, cmd.div_step, div_cnt < DCNT_W'(DIV_STEPS), "divider ran past its last step")

endmodule

// ===== rtl/spectrum_energy_level_detector.sv =====
// Spectrum energy level detector.
// spec_in (sink) takes one word per spectrum bin or per millisecond tick;
// command selects which. Bin words stream at one per cycle while idle. The
// word that carries frame_end closes the frame: the band occupancy ratio is
// divided out one quotient bit per cycle (17 steps), low-pass filtered on one
// shared 17x17 multiplier, then classified calm/low/high with hysteresis.
// level_out (source) carries one word per frame; ticks and other bins give none.
// After the frame_end word, spec_in.ready stays low through the ratio pass:
// denominator, divider preparation, the divider steps, the two multiplies,
// the blend and classification; the result word is then registered.
// level_out has an output register: the next frame streams in while a result
// waits; if the receiver still stalls when the following frame is finished,
// that frame's ratio pass holds and spec_in stays not ready until it drains.
// cfg_we/cfg_index/cfg_data write one register per cycle; write only while idle.
// Reset (rst, synchronous) restores the register defaults, clears the frame
// accumulators, the level filter, the millisecond clock and the cut counter,
// and drops any pending result word.
module spectrum_energy_level_detector
  import seld_pkg::*;
#(
  parameter int NUM_BINS      = NUM_BINS_DEF,
  parameter int WINDOW_HEIGHT = WINDOW_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  seld_stream_if.sink           spec_in,
  seld_stream_if.source         level_out
);

  seld_cmd_t    cmd;
  seld_status_t status;
  seld_in_t     in_word;
  seld_out_t    out_word;
  logic         in_ready;
  logic         out_valid;

  assign in_word         = spec_in.payload;
  assign spec_in.ready   = in_ready;
  assign level_out.valid = out_valid;
  assign level_out.payload = out_word;

  // Sequencer: accepts words, walks the per-frame ratio pass, owns out valid.
  seld_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (spec_in.valid),
    .in_command   (in_word.command),
    .in_frame_end (in_word.frame_end),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (level_out.ready),
    .cmd          (cmd),
    .status       (status)
  );

  // Accumulators, divider, filter, classifier and the result register.
  seld_datapath #(
    .NUM_BINS      (NUM_BINS),
    .WINDOW_HEIGHT (WINDOW_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_word),
    .out_word  (out_word)
  );

endmodule

// ===== tb/sv/tb_spectrum_energy_level_detector.sv =====
`timescale 1ns / 1ps

module tb_spectrum_energy_level_detector;
  import seld_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 6;
  // Settle time after each drain, with margin over a full ratio pass
  localparam int SETTLE_CYCLES = 40;
  // Receiver hold-off long enough to back up several short frames
  localparam int HOLD_CYCLES   = 300;
  // Longest correct quiet stretch is the hold-off plus a phase change
  localparam int STALL_LIMIT   = 3000;
  localparam int IDLE_PCT      = 33;
  localparam int MAX_REPORTS   = 10;
  localparam int TICK_PCT      = 15;
  localparam longint unsigned HEIGHT_CAP = 64'(WINDOW_HEIGHT_DEF) << FRAC_W;

  // One full register set, in register index order
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [BAND_W-1:0] band_start;
    logic              mixdown;
    logic [LVL_W-1:0]  smoothing;
    logic [LVL_W-1:0]  thr_a;
    logic [LVL_W-1:0]  thr_b;
    logic [LVL_W-1:0]  thr_c;
    logic [INTV_W-1:0] cut_gap;
  } detector_settings_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  seld_stream_if #(.payload_t(seld_in_t))  spec_in_if ();
  seld_stream_if #(.payload_t(seld_out_t)) level_out_if ();

  spectrum_energy_level_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .spec_in   (spec_in_if),
    .level_out (level_out_if)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Mirror of the detector: register copy plus frame and level state
  detector_settings_t live_cfg;
  logic [BAND_W-1:0]  bin_pos     = '0;
  logic [SUM_W-1:0]   band_sum    = '0;
  logic [BINS_W-1:0]  band_bins   = '0;
  logic [LVL_W-1:0]   level       = '0;
  level_class_t       lvl_state   = CLASS_CALM;
  logic [MS_W-1:0]    now_ms      = '0;
  logic [MS_W-1:0]    last_cut_ms = '0;
  logic [CUT_W-1:0]   cut_ctr     = '0;

  // Words waiting to be offered, and level words still owed by the block
  seld_in_t  pending_words[$];
  seld_out_t level_due[$];

  int   words_queued = 0;
  int   words_in     = 0;
  int   ticks_in     = 0;
  int   results_in   = 0;
  int   cuts_in      = 0;
  int   fail_count   = 0;
  int   quiet_cycles = 0;
  int   class_hits[3] = '{0, 0, 0};
  logic in_taken     = 1'b0;
  logic steady_flow  = 1'b0;
  int   hold_left    = 0;
  int   hold_asked   = 0;
  int   hold_served  = 0;

  // Advance the mirror by one accepted input word; owe a level word on frame_end.
  task automatic track_word(input seld_in_t w);
    logic [MAG_W-1:0]  mag;
    longint unsigned   height;
    longint unsigned   acc;
    longint unsigned   ratio;
    longint unsigned   weight;
    longint unsigned   blend;
    logic [LVL_W-1:0]  th_lo, th_mid, th_hi, swap;
    logic [MS_W-1:0]   elapsed;
    logic              entering_high;
    logic              fired;
    seld_out_t         owed;
    entering_high = 1'b0;
    fired         = 1'b0;
    if (w.command == CMD_TICK) begin
      now_ms = now_ms + 1'b1;
      ticks_in++;
      return;
    end
    mag    = live_cfg.mixdown ? w.bin_mixdown : w.bin_normal;
    height = (64'(mag) * 64'(live_cfg.gain)) >> FRAC_W;
    if (height > HEIGHT_CAP) height = HEIGHT_CAP;
    // Band is start <= bin < NUM_BINS - start; a start past NUM_BINS empties it
    if (bin_pos >= live_cfg.band_start && live_cfg.band_start <= NUM_BINS_DEF &&
        int'(bin_pos) < NUM_BINS_DEF - int'(live_cfg.band_start)) begin
      acc      = 64'(band_sum) + height;
      band_sum = (acc > 64'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
      if (band_bins < BINS_MAX) band_bins = band_bins + 1'b1;
    end
    // Overlong frames park the position at NUM_BINS, outside any band
    if (bin_pos < NUM_BINS_DEF) bin_pos = bin_pos + 1'b1;
    if (!w.frame_end) return;

    if (band_bins == 0) begin
      ratio = 0;
    end else begin
      ratio = (64'(band_sum) << FRAC_W) / (64'(band_bins) * WINDOW_HEIGHT_DEF);
      if (ratio > 64'(ONE_Q16)) ratio = 64'(ONE_Q16);
    end
    weight = (live_cfg.smoothing > ONE_Q16) ? 64'(ONE_Q16) : 64'(live_cfg.smoothing);
    // Q1.16 low-pass with round-half-up
    blend  = (ratio * weight + 64'(level) * (64'(ONE_Q16) - weight) + ROUND_Q16) >> 16;
    level  = blend[LVL_W-1:0];
    bin_pos   = '0;
    band_sum  = '0;
    band_bins = '0;

    // Sort the thresholds: smallest calm, middle low, largest high
    th_lo  = live_cfg.thr_a;
    th_mid = live_cfg.thr_b;
    th_hi  = live_cfg.thr_c;
    if (th_lo > th_mid) begin swap = th_lo; th_lo = th_mid; th_mid = swap; end
    if (th_mid > th_hi) begin swap = th_mid; th_mid = th_hi; th_hi = swap; end
    if (th_lo > th_mid) begin swap = th_lo; th_lo = th_mid; th_mid = swap; end

    case (lvl_state)
      CLASS_HIGH: begin
        if (level < th_lo) lvl_state = CLASS_CALM;
        else if (level < th_mid) lvl_state = CLASS_LOW;
      end
      CLASS_LOW: begin
        if (th_hi < level) begin
          lvl_state     = CLASS_HIGH;
          entering_high = 1'b1;
        end else if (level < th_lo) begin
          lvl_state = CLASS_CALM;
        end
      end
      default: begin
        if (th_hi < level) begin
          lvl_state     = CLASS_HIGH;
          entering_high = 1'b1;
        end
      end
    endcase

    // A cut needs strictly more than the interval since the last one
    elapsed = now_ms - last_cut_ms;
    if (entering_high && MS_W'(live_cfg.cut_gap) < elapsed) begin
      fired       = 1'b1;
      last_cut_ms = now_ms;
      cut_ctr     = cut_ctr + 1'b1;
      if (cut_ctr > CUT_WRAP) cut_ctr = '0;
    end

    owed.energy_level = level;
    owed.level_class  = lvl_state;
    owed.cut_change   = fired;
    owed.cut_count    = cut_ctr;
    level_due.push_back(owed);
  endtask

  // Match one delivered level word against the oldest one owed.
  task automatic check_level(input seld_out_t got);
    seld_out_t want;
    results_in++;
    if (got.cut_change) cuts_in++;
    if (got.level_class <= CLASS_HIGH) class_hits[got.level_class]++;
    if (level_due.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected level word: level %0d class %0d cut %b count %0d",
                 $realtime, got.energy_level, got.level_class, got.cut_change,
                 got.cut_count);
    end else begin
      want = level_due.pop_front();
      if (got.energy_level !== want.energy_level || got.level_class !== want.level_class ||
          got.cut_change !== want.cut_change || got.cut_count !== want.cut_count) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: level word %0d: expected %0d/%0d/%b/%0d, got %0d/%0d/%b/%0d",
                   $realtime, results_in, want.energy_level, want.level_class,
                   want.cut_change, want.cut_count, got.energy_level, got.level_class,
                   got.cut_change, got.cut_count);
      end
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  // Write every register, then take the new set into the mirror.
  task automatic program_settings(input detector_settings_t s);
    write_reg(CFG_GAIN,        CFG_DATA_W'(s.gain));
    write_reg(CFG_BAND_START,  CFG_DATA_W'(s.band_start));
    write_reg(CFG_USE_MIXDOWN, CFG_DATA_W'(s.mixdown));
    write_reg(CFG_SMOOTHING,   s.smoothing);
    write_reg(CFG_THRESHOLD_A, s.thr_a);
    write_reg(CFG_THRESHOLD_B, s.thr_b);
    write_reg(CFG_THRESHOLD_C, s.thr_c);
    write_reg(CFG_CUT_INTV,    CFG_DATA_W'(s.cut_gap));
    @(negedge clk);
    cfg_we   <= 1'b0;
    live_cfg  = s;
  endtask

  task automatic add_word(input logic cmd, input logic [MAG_W-1:0] normal,
                          input logic [MAG_W-1:0] mixdown, input logic last);
    seld_in_t w;
    w.command     = cmd;
    w.bin_normal  = normal;
    w.bin_mixdown = mixdown;
    w.frame_end   = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Magnitudes lean on the ends of the range and on small values
  function automatic logic [MAG_W-1:0] pick_mag();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return MAG_W'($urandom_range(255));
      default: return MAG_W'($urandom);
    endcase
  endfunction

  // One frame of len bins, with ticks scattered in between
  task automatic queue_frame(input int len, input int tick_pct);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(99) < tick_pct)
        add_word(CMD_TICK, MAG_W'($urandom), MAG_W'($urandom), 1'($urandom_range(1)));
      add_word(CMD_BIN, pick_mag(), pick_mag(), k == len - 1);
    end
  endtask

  task automatic queue_random_frames(input int budget, input int max_len);
    int start;
    start = words_queued;
    while (words_queued - start < budget) queue_frame($urandom_range(max_len, 1), TICK_PCT);
  endtask

  function automatic detector_settings_t pick_settings();
    detector_settings_t s;
    s.gain       = ($urandom_range(3) == 0) ? '1 : GAIN_W'($urandom_range(2048, 64));
    s.band_start = BAND_W'($urandom_range(6));
    s.mixdown    = 1'($urandom_range(1));
    s.smoothing  = ($urandom_range(3) == 0) ? ONE_Q16 : LVL_W'($urandom_range(65536));
    s.thr_a      = LVL_W'($urandom_range(50000));
    s.thr_b      = LVL_W'($urandom_range(50000));
    s.thr_c      = LVL_W'($urandom_range(50000));
    s.cut_gap    = INTV_W'($urandom_range(12));
    return s;
  endfunction

  // Wait until every queued word is in and every owed level word is out,
  // then let the block settle before touching its registers.
  task automatic drain_and_settle();
    while (words_in != words_queued || level_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: offer the next pending word at the falling edge, sometimes idle.
  always @(negedge clk) begin
    if (rst) begin
      spec_in_if.valid <= 1'b0;
    end else if (!spec_in_if.valid || in_taken) begin
      if (pending_words.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
        spec_in_if.valid   <= 1'b1;
        spec_in_if.payload <= pending_words.pop_front();
      end else begin
        spec_in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (rst) begin
      level_out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      level_out_if.ready <= 1'b0;
      hold_left          <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      level_out_if.ready <= 1'b0;
      hold_left          <= HOLD_CYCLES;
      hold_served        <= hold_asked;
    end else begin
      level_out_if.ready <= steady_flow || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Monitor: sample both channels at the rising edge; check results first so a
  // word owed at this edge cannot be consumed by a stray result.
  always @(posedge clk) begin
    in_taken <= !rst && spec_in_if.valid && spec_in_if.ready;
    if (!rst && level_out_if.valid && level_out_if.ready) check_level(level_out_if.payload);
    if (!rst && spec_in_if.valid && spec_in_if.ready) begin
      track_word(spec_in_if.payload);
      words_in++;
    end
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (spec_in_if.valid && spec_in_if.ready) ||
        (level_out_if.valid && level_out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d level words still owed",
               STALL_LIMIT, level_due.size());
      $display("spectrum_energy_level_detector regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    detector_settings_t s;
    spec_in_if.valid   = 1'b0;
    spec_in_if.payload = '0;
    level_out_if.ready = 1'b0;
    live_cfg = '{gain: GAIN_RST, band_start: BAND_RST, mixdown: 1'b0,
                 smoothing: SMOOTH_RST, thr_a: THR_A_RST, thr_b: THR_B_RST,
                 thr_c: THR_C_RST, cut_gap: CUT_INTV_RST};

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: the band starts at bin 128, so short frames see an empty band
    add_word(CMD_TICK, '0, '1, 1'b0);
    add_word(CMD_BIN, '1, '0, 1'b1);
    add_word(CMD_BIN, '0, '1, 1'b0);
    add_word(CMD_BIN, '1, '1, 1'b1);
    drain_and_settle();

    // Directed: full-scale gain clips full-scale bins, smoothing of one passes the
    // ratio straight through, thresholds written out of order
    s = '{gain: '1, band_start: '0, mixdown: 1'b0, smoothing: ONE_Q16,
          thr_a: 17'd40000, thr_b: 17'd1000, thr_c: 17'd20000, cut_gap: '0};
    program_settings(s);
    add_word(CMD_TICK, '1, '1, 1'b1);   // tick with every field set: ignored
    add_word(CMD_BIN, '1, '0, 1'b1);    // clipped full scale: calm to high, cut fires
    add_word(CMD_BIN, '0, '1, 1'b1);    // silent bin: straight back to calm
    add_word(CMD_BIN, '1, '0, 1'b0);    // half-scale two-bin frame: stays calm
    add_word(CMD_BIN, '0, '1, 1'b1);
    add_word(CMD_TICK, '0, '0, 1'b0);
    add_word(CMD_BIN, '1, '1, 1'b1);    // high again, one tick later: cut fires
    add_word(CMD_BIN, 16'd54, '0, 1'b1); // ratio near 10000: high drops to low
    add_word(CMD_BIN, '1, '0, 1'b1);    // low to high with no tick since: no cut
    add_word(CMD_BIN, '0, '0, 1'b1);    // calm
    drain_and_settle();

    // Random frames under random settings; the receiver holds off meanwhile so
    // finished frames back up and the input stalls
    program_settings(pick_settings());
    hold_asked++;
    queue_random_frames(150, 10);
    drain_and_settle();

    // Steady stream of quiet/loud frame pairs on the mixdown spectrum: each loud
    // frame enters high, enough cuts to wrap the counter. Smoothing above one.
    s = '{gain: GAIN_RST, band_start: '0, mixdown: 1'b1, smoothing: 17'd100000,
          thr_a: 17'd30000, thr_b: 17'd2000, thr_c: 17'd500, cut_gap: '0};
    program_settings(s);
    steady_flow = 1'b1;
    for (int k = 0; k < 115; k++) begin
      // skip the tick now and then: the next loud frame enters high without a cut
      if (k % 10 != 9) add_word(CMD_TICK, MAG_W'($urandom), MAG_W'($urandom), 1'b0);
      add_word(CMD_BIN, pick_mag(), MAG_W'($urandom_range(3)), 1'b1);
      if ($urandom_range(1)) add_word(CMD_BIN, pick_mag(), MAG_W'($urandom_range(16'hFFFF, 16'hC000)), 1'b0);
      add_word(CMD_BIN, pick_mag(), MAG_W'($urandom_range(16'hFFFF, 16'hC000)), 1'b1);
    end
    drain_and_settle();
    steady_flow = 1'b0;

    // Overlong frame: bins past NUM_BINS never count
    s = '{gain: 16'd200, band_start: 10'd100, mixdown: 1'b0, smoothing: 17'd40000,
          thr_a: ONE_Q16, thr_b: '0, thr_c: 17'd20000, cut_gap: '1};
    program_settings(s);
    queue_frame(NUM_BINS_DEF + 1, 0);
    for (int k = 0; k < 3; k++) queue_frame(3, TICK_PCT);
    drain_and_settle();

    // Low extremes: zero gain and smoothing, band starting at NUM_BINS (empty)
    s = '{gain: '0, band_start: 10'd512, mixdown: 1'b1, smoothing: '0,
          thr_a: '1, thr_b: '1, thr_c: '1, cut_gap: '1};
    program_settings(s);
    for (int k = 0; k < 4; k++) queue_frame(4, TICK_PCT);
    drain_and_settle();

    // High extremes: band start past NUM_BINS also gives an empty band
    s = '{gain: '1, band_start: '1, mixdown: 1'b0, smoothing: '1,
          thr_a: '0, thr_b: '0, thr_c: '0, cut_gap: '0};
    program_settings(s);
    for (int k = 0; k < 3; k++) queue_frame(4, TICK_PCT);
    drain_and_settle();

    // One more random round
    program_settings(pick_settings());
    queue_random_frames(60, 12);
    drain_and_settle();

    $display("run covered %0d input words (%0d ticks), %0d level words checked, %0d cuts",
             words_in, ticks_in, results_in, cuts_in);
    $display("classes seen: calm %0d, low %0d, high %0d; %0d mismatches",
             class_hits[0], class_hits[1], class_hits[2], fail_count);
    if (fail_count == 0)
      $display("spectrum_energy_level_detector regression: pass");
    else
      $display("spectrum_energy_level_detector regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/seld_pkg.sv
rtl/seld_stream_if.sv
rtl/seld_ctrl.sv
rtl/seld_datapath.sv
rtl/spectrum_energy_level_detector.sv
tb/sv/tb_spectrum_energy_level_detector.sv
